FILE: design/fte_pkg.sv
// Package for the fault table: entry layout, operation/status/event codes,
// controller state and the command/status words between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package fte_pkg;

  localparam int TABLE_DEPTH_DEF = 8;

  localparam logic [2:0] OP_REGISTER  = 3'd0;
  localparam logic [2:0] OP_REPORT    = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_RECOVERED = 3'd3;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_UNKNOWN = 2'd2;

  localparam logic [1:0] EV_SET     = 2'd0;
  localparam logic [1:0] EV_LATCHED = 2'd1;
  localparam logic [1:0] EV_CLEARED = 2'd2;

  typedef enum logic [1:0] {
    FS_INACTIVE = 2'd0,
    FS_ACTIVE   = 2'd1,
    FS_LATCHED  = 2'd2
  } fstate_t;

  typedef struct packed {
    logic [15:0] ident;
    logic [1:0]  sev;
    fstate_t     state;
    logic [7:0]  retries;
    logic [7:0]  limit;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EXEC
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch the input word, reset scan
    logic scan;   // issue table read at scan index
    logic exec;   // apply the update and register the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;      // table holds no entries
    logic scan_last;  // scan index is at the last used entry
  } stat_t;

endpackage

FILE: design/fte_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module fte_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/fte_ctrl.sv
// Sequencer for the fault table: accept, scan the used entries, drain the
// read pipe, execute. Depends on fte_pkg.
`timescale 1ns / 1ps
module fte_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fte_pkg::stat_t stat,
  output fte_pkg::cmd_t  cmd,
  output logic          busy
);

  fte_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fte_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fte_pkg::S_IDLE: begin
        if (start) begin
          state_next = stat.empty ? fte_pkg::S_EXEC : fte_pkg::S_SCAN;
        end
      end
      fte_pkg::S_SCAN: begin
        if (stat.scan_last) begin
          state_next = fte_pkg::S_DRAIN;
        end
      end
      fte_pkg::S_DRAIN: state_next = fte_pkg::S_EXEC;
      fte_pkg::S_EXEC:  state_next = fte_pkg::S_IDLE;
      default:          state_next = fte_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      fte_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      fte_pkg::S_SCAN:  cmd.scan = 1'b1;
      fte_pkg::S_DRAIN: cmd = '0;
      fte_pkg::S_EXEC:  cmd.exec = 1'b1;
      default:          cmd = '0;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> !cmd.exec)
    else $error("exec held more than one cycle");

  a_scan_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !stat.empty)
    else $error("scan issued on empty table");

endmodule

FILE: design/fte_datapath.sv
// Fault table datapath: entry RAM, scan registers (first match, severity
// maximum of the other active entries), update logic and result registers.
// Depends on fte_pkg and fte_ram.
`timescale 1ns / 1ps
module fte_datapath #(
  parameter int TABLE_DEPTH = fte_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  fte_pkg::cmd_t  cmd,
  output fte_pkg::stat_t stat,
  input  logic [2:0]     operation,
  input  logic [15:0]    fault_ident,
  input  logic [1:0]     severity,
  input  logic [7:0]     retry_limit,
  output logic           done,
  output logic [1:0]     status,
  output logic           event_valid,
  output logic [1:0]     event_kind,
  output logic [1:0]     event_severity,
  output logic           is_active,
  output logic           is_latched,
  output logic [1:0]     max_active_severity
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // latched input word
  logic [2:0]  op_q;
  logic [15:0] id_q;
  logic [1:0]  sev_q;
  logic [7:0]  lim_q;

  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] idx;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;

  logic                         hit;
  logic [IDX_W-1:0]             hit_idx;
  fte_pkg::entry_t              hit_entry;
  logic [1:0]                   max_other;

  logic [fte_pkg::ENTRY_W-1:0]  rd_data;
  fte_pkg::entry_t              rd_entry;

  // update logic
  logic                 full;
  logic                 wr;
  logic [IDX_W-1:0]     waddr;
  fte_pkg::entry_t      wentry;
  fte_pkg::fstate_t     ns;
  logic [1:0]           sts_c;
  logic                 ev_v;
  logic [1:0]           ev_k;
  logic [1:0]           ev_s;
  logic                 cnt_inc;
  logic [7:0]           retries_eff;
  logic [1:0]           hit_sev_c;
  logic [1:0]           max_c;

  fte_ram #(
    .WIDTH (fte_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && wr),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (idx),
    .rdata (rd_data)
  );

  assign rd_entry       = rd_data;
  assign full           = (entry_count == CNT_W'(TABLE_DEPTH));
  assign stat.empty     = (entry_count == '0);
  assign stat.scan_last = ((CNT_W'(idx) + CNT_W'(1)) == entry_count);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      id_q  <= fault_ident;
      sev_q <= severity;
      lim_q <= retry_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      idx         <= '0;
      rd_pend     <= 1'b0;
      hit         <= 1'b0;
      done        <= 1'b0;
    end else begin
      rd_pend <= cmd.scan;
      done    <= cmd.exec;
      if (cmd.load) begin
        idx <= '0;
        hit <= 1'b0;
      end else if (cmd.scan) begin
        idx <= idx + IDX_W'(1);
      end
      if (rd_pend && !hit && rd_entry.ident == id_q) begin
        hit <= 1'b1;
      end
      if (cmd.exec && cnt_inc) begin
        entry_count <= entry_count + CNT_W'(1);
      end
    end
  end

  // scan payload: first match kept aside, the other active entries fold into the maximum
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx <= idx;
    end
    if (cmd.load) begin
      max_other <= '0;
    end else if (rd_pend) begin
      if (!hit && rd_entry.ident == id_q) begin
        hit_idx   <= rd_idx;
        hit_entry <= rd_entry;
      end else if (rd_entry.state != fte_pkg::FS_INACTIVE && rd_entry.sev > max_other) begin
        max_other <= rd_entry.sev;
      end
    end
  end

  always_comb begin
    wr          = 1'b0;
    waddr       = hit_idx;
    wentry      = hit_entry;
    ns          = hit_entry.state;
    sts_c       = fte_pkg::STS_OK;
    ev_v        = 1'b0;
    ev_k        = fte_pkg::EV_SET;
    ev_s        = 2'd0;
    cnt_inc     = 1'b0;
    retries_eff = (hit_entry.state == fte_pkg::FS_INACTIVE) ? 8'd0 : hit_entry.retries;
    case (op_q) inside
      fte_pkg::OP_REGISTER: begin
        if (full) begin
          sts_c = fte_pkg::STS_FULL;
        end else begin
          wr             = 1'b1;
          cnt_inc        = 1'b1;
          waddr          = entry_count[IDX_W-1:0];
          wentry.ident   = id_q;
          wentry.sev     = sev_q;
          wentry.state   = fte_pkg::FS_INACTIVE;
          wentry.retries = 8'd0;
          wentry.limit   = lim_q;
        end
      end
      fte_pkg::OP_REPORT: begin
        if (!hit) begin
          sts_c = fte_pkg::STS_UNKNOWN;
        end else if (hit_entry.state != fte_pkg::FS_LATCHED) begin
          wr   = 1'b1;
          ev_v = 1'b1;
          ev_s = hit_entry.sev;
          if (retries_eff >= hit_entry.limit) begin
            ns             = fte_pkg::FS_LATCHED;
            ev_k           = fte_pkg::EV_LATCHED;
            wentry.retries = retries_eff;
          end else begin
            ns             = fte_pkg::FS_ACTIVE;
            wentry.retries = retries_eff + 8'd1;
          end
          wentry.state = ns;
        end
      end
      fte_pkg::OP_CLEAR, fte_pkg::OP_RECOVERED: begin
        if (!hit) begin
          sts_c = fte_pkg::STS_UNKNOWN;
        end else if ((op_q == fte_pkg::OP_CLEAR && hit_entry.state != fte_pkg::FS_INACTIVE)
                  || hit_entry.state == fte_pkg::FS_ACTIVE) begin
          wr             = 1'b1;
          ns             = fte_pkg::FS_INACTIVE;
          wentry.state   = fte_pkg::FS_INACTIVE;
          wentry.retries = 8'd0;
          ev_v           = 1'b1;
          ev_k           = fte_pkg::EV_CLEARED;
          ev_s           = hit_entry.sev;
        end
      end
      default: begin
        if (!hit) begin
          sts_c = fte_pkg::STS_UNKNOWN;
        end
      end
    endcase
    hit_sev_c = (hit && ns != fte_pkg::FS_INACTIVE) ? hit_entry.sev : 2'd0;
    max_c     = (hit_sev_c > max_other) ? hit_sev_c : max_other;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status              <= sts_c;
      event_valid         <= ev_v;
      event_kind          <= ev_k;
      event_severity      <= ev_s;
      is_active           <= hit && ns != fte_pkg::FS_INACTIVE;
      is_latched          <= hit && ns == fte_pkg::FS_LATCHED;
      max_active_severity <= max_c;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_event_ok: assert property (@(posedge clk) disable iff (rst)
    done && event_valid |-> status == fte_pkg::STS_OK)
    else $error("event issued on failed word");

  a_latched_active: assert property (@(posedge clk) disable iff (rst)
    done && is_latched |-> is_active)
    else $error("latched flag without active flag");

endmodule

FILE: design/fault_table_escalation.sv
// Fault collection table with retry escalation, top level.
// Depends on fte_pkg, fte_ctrl, fte_datapath (which holds fte_ram).
//
//  channel  handshake        fields
//  ------   ---------------  ----------------------------------------------
//  input    start & !busy    operation, fault_ident, severity, retry_limit
//  result   done (1 cycle)   status, event_valid, event_kind, event_severity,
//                            is_active, is_latched, max_active_severity
//
// A word scans the used entries through the entry RAM, one read per cycle,
// then drains the read pipe and executes (at once with an empty table); done
// is registered from execute, and a new word can be taken in the done cycle.
// Synchronous active-high reset empties the table; entry storage is not cleared.
// The receiver cannot stall: done marks each result for a single cycle.
`timescale 1ns / 1ps
module fault_table_escalation #(
  parameter int TABLE_DEPTH = fte_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [15:0] fault_ident,
  input  logic [1:0]  severity,
  input  logic [7:0]  retry_limit,
  output logic        done,
  output logic [1:0]  status,
  output logic        event_valid,
  output logic [1:0]  event_kind,
  output logic [1:0]  event_severity,
  output logic        is_active,
  output logic        is_latched,
  output logic [1:0]  max_active_severity
);

  fte_pkg::cmd_t  cmd;
  fte_pkg::stat_t stat;

  fte_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fte_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .operation           (operation),
    .fault_ident         (fault_ident),
    .severity            (severity),
    .retry_limit         (retry_limit),
    .done                (done),
    .status              (status),
    .event_valid         (event_valid),
    .event_kind          (event_kind),
    .event_severity      (event_severity),
    .is_active           (is_active),
    .is_latched          (is_latched),
    .max_active_severity (max_active_severity)
  );

endmodule
